[hw/rtl/bba_pkg.sv]
// Shared constants, types and state codes for the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    // Bitmap word geometry: one bit per block, WORD_BITS blocks per memory word
    localparam int WORD_BITS = 32;
    localparam int OFF_W     = 5;

    // Block number field width and the span it can express
    localparam int BLOCK_W    = 15;
    localparam int FIELD_SPAN = 32768;

    localparam int DEFAULT_BLOCK_COUNT = 32768;

    // Register decode (byte address bit 2)
    localparam logic REG_ALLOC_START = 1'b0;
    localparam logic REG_FREE_FLOOR  = 1'b1;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ALLOC,
        ST_FREE
    } t_state;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] idx;
    } t_scan;

endpackage

[hw/rtl/bitmap_block_allocator.sv]
// Top level: first-fit bitmap block allocator with APB configuration port.
`timescale 1ns / 1ps
// Accept to result beat: a refused free or alloc with start past the limit answers in the
// next cycle; a free in range reads, then modifies and writes its word; an alloc scans
// from the start word to a hit or the last word, the single RAM read port streaming
// one word per cycle. Throughput: one item at a time, busy high while a request is in
// the ALLOC or FREE state and low again in its result beat. The receiver cannot stall.
// Reset: synchronous, active low; then a clearing pass over all DEPTH words, busy high.

module bitmap_block_allocator #(
    parameter int BLOCK_COUNT = bba_pkg::DEFAULT_BLOCK_COUNT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [bba_pkg::BLOCK_W-1:0] i_block_in,

    // result channel (one-cycle strobe)
    output logic                       o_valid,
    output logic [bba_pkg::BLOCK_W-1:0] o_block_out,
    output logic                       o_ok,

    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int WB        = bba_pkg::WORD_BITS;
    localparam int OW        = bba_pkg::OFF_W;
    localparam int BW        = bba_pkg::BLOCK_W;
    localparam int DEPTH     = (BLOCK_COUNT + WB - 1) / WB;
    localparam int AW        = $clog2(DEPTH);
    // Blocks above the field span can never be handed out
    localparam int LIMIT     = (BLOCK_COUNT > bba_pkg::FIELD_SPAN) ?
                               bba_pkg::FIELD_SPAN : BLOCK_COUNT;
    localparam int LAST_WORD = (LIMIT - 1) / WB;
    localparam int LAST_BITS = LIMIT - LAST_WORD * WB;

    localparam logic [AW-1:0] LAST_ADDR  = AW'(LAST_WORD);
    localparam logic [AW-1:0] DEPTH_LAST = AW'(DEPTH - 1);
    localparam logic [31:0]   LIMIT32    = 32'(LIMIT);
    localparam logic [31:0]   COUNT32    = 32'(BLOCK_COUNT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BW-1:0] r_alloc_start;
    logic [BW-1:0] r_free_floor;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_start <= '0;
            r_free_floor  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                bba_pkg::REG_ALLOC_START: r_alloc_start <= pwdata[BW-1:0];
                bba_pkg::REG_FREE_FLOOR:  r_free_floor  <= pwdata[BW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bba_pkg::REG_ALLOC_START: prdata = 32'(r_alloc_start);
            bba_pkg::REG_FREE_FLOOR:  prdata = 32'(r_free_floor);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Bitmap memory
    // ------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [WB-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [WB-1:0] ram_rdata;

    bba_ram #(
        .WIDTH (WB),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    bba_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr;      // clearing pass pointer
    logic [AW-1:0]   r_raddr;    // next word to read during a scan
    logic [AW-1:0]   r_paddr;    // word whose data is on ram_rdata
    logic [BW-1:0]   r_blk;      // block being freed
    logic [AW-1:0]   n_raddr;

    logic          r_valid, n_valid;
    logic [BW-1:0] r_block_out, n_block_out;
    logic          r_ok, n_ok;

    // Word and bit position decode of the request and of the start block
    logic [31:0]   start_ext;
    logic [31:0]   blk_ext;
    logic [31:0]   rblk_ext;
    logic [AW-1:0] start_word;
    logic [AW-1:0] blk_word;
    logic [AW-1:0] rblk_word;
    logic          accept;
    logic          start_ok;
    logic          free_ok;

    assign start_ext  = 32'(r_alloc_start) >> OW;
    assign blk_ext    = 32'(i_block_in) >> OW;
    assign rblk_ext   = 32'(r_blk) >> OW;
    assign start_word = start_ext[AW-1:0];
    assign blk_word   = blk_ext[AW-1:0];
    assign rblk_word  = rblk_ext[AW-1:0];

    assign accept   = start && !busy;
    assign start_ok = 32'(r_alloc_start) < LIMIT32;
    assign free_ok  = (i_block_in >= r_free_floor) && (32'(i_block_in) < COUNT32);

    // Word search on the data that comes back from the memory
    bba_pkg::t_scan scan;

    bba_scan #(
        .LAST_BITS (LAST_BITS)
    ) u_scan (
        .i_word   (ram_rdata),
        .i_first  (r_paddr == start_word),
        .i_offset (r_alloc_start[OW-1:0]),
        .i_last   (r_paddr == LAST_ADDR),
        .o_res    (scan)
    );

    logic [31:0] found_ext;
    assign found_ext = (32'(r_paddr) << OW) | 32'(scan.idx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bba_pkg::ST_CLEAR: begin
                if (r_clr == DEPTH_LAST) n_state = bba_pkg::ST_IDLE;
            end
            bba_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == bba_pkg::CMD_ALLOC && start_ok) begin
                        n_state = bba_pkg::ST_ALLOC;
                    end else if (i_cmd == bba_pkg::CMD_FREE && free_ok) begin
                        n_state = bba_pkg::ST_FREE;
                    end
                end
            end
            bba_pkg::ST_ALLOC: begin
                if (scan.found || r_paddr == LAST_ADDR) n_state = bba_pkg::ST_IDLE;
            end
            bba_pkg::ST_FREE: begin
                n_state = bba_pkg::ST_IDLE;
            end
            default: n_state = bba_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and result
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_paddr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_raddr;
        n_valid     = 1'b0;
        n_block_out = r_block_out;
        n_ok        = r_ok;
        unique case (r_state)
            bba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            bba_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_cmd == bba_pkg::CMD_ALLOC) begin
                        if (start_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = start_word;
                        end else begin
                            n_valid     = 1'b1;
                            n_block_out = '0;
                            n_ok        = 1'b0;
                        end
                    end else begin
                        if (free_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = blk_word;
                        end else begin
                            n_valid     = 1'b1;
                            n_block_out = i_block_in;
                            n_ok        = 1'b0;
                        end
                    end
                end
            end
            bba_pkg::ST_ALLOC: begin
                // keep streaming reads; a word read past a hit is dropped
                ram_re = 1'b1;
                if (scan.found) begin
                    ram_we      = 1'b1;
                    ram_waddr   = r_paddr;
                    ram_wdata   = ram_rdata | (WB'(1) << scan.idx);
                    n_valid     = 1'b1;
                    n_block_out = found_ext[BW-1:0];
                    n_ok        = 1'b1;
                end else if (r_paddr == LAST_ADDR) begin
                    n_valid     = 1'b1;
                    n_block_out = '0;
                    n_ok        = 1'b0;
                end
            end
            bba_pkg::ST_FREE: begin
                ram_we      = 1'b1;
                ram_waddr   = rblk_word;
                ram_wdata   = ram_rdata & ~(WB'(1) << r_blk[OW-1:0]);
                n_valid     = 1'b1;
                n_block_out = r_blk;
                n_ok        = 1'b1;
            end
            default: ;
        endcase
    end

    // scan pointer stops at the last word
    assign n_raddr = (ram_raddr == LAST_ADDR) ? ram_raddr : ram_raddr + AW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (r_state == bba_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_block_out <= n_block_out;
        r_ok        <= n_ok;
        if (ram_re) begin
            r_paddr <= ram_raddr;
            r_raddr <= n_raddr;
        end
        if (accept) begin
            r_blk <= i_block_in;
        end
    end

    assign busy        = (r_state != bba_pkg::ST_IDLE);
    assign o_valid     = r_valid;
    assign o_block_out = r_block_out;
    assign o_ok        = r_ok;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_ALLOC) |-> (r_paddr <= LAST_ADDR))
        else $error("alloc scan ran past the last bitmap word");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_CLEAR) |-> !o_valid)
        else $error("result beat during the clearing pass");

    a_alloc_above_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok && $past(r_state == bba_pkg::ST_ALLOC))
            |-> (o_block_out >= r_alloc_start))
        else $error("allocated block below alloc_start");

    a_alloc_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok && $past(r_state == bba_pkg::ST_ALLOC))
            |-> (32'(o_block_out) < LIMIT32))
        else $error("allocated block beyond the block limit");

endmodule

[hw/rtl/bba_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bba_scan.sv]
// Finds the lowest clear bit of one bitmap word inside the allowed bit window.
`timescale 1ns / 1ps

module bba_scan #(
    parameter int LAST_BITS = bba_pkg::WORD_BITS
) (
    input  logic [bba_pkg::WORD_BITS-1:0] i_word,
    input  logic                          i_first,
    input  logic [bba_pkg::OFF_W-1:0]     i_offset,
    input  logic                          i_last,
    output bba_pkg::t_scan                o_res
);

    logic [bba_pkg::WORD_BITS-1:0] avail;

    // A bit is a candidate when clear, at or above the start offset in the
    // first word, and below the block limit in the last word.
    always_comb begin
        for (int i = 0; i < bba_pkg::WORD_BITS; i++) begin
            avail[i] = !i_word[i]
                     && (!i_first || ((bba_pkg::OFF_W+1)'(i) >= {1'b0, i_offset}))
                     && (!i_last || (i < LAST_BITS));
        end
    end

    always_comb begin
        o_res.found = |avail;
        o_res.idx   = '0;
        for (int i = bba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (avail[i]) begin
                o_res.idx = bba_pkg::OFF_W'(i);
            end
        end
    end

endmodule
